FILE: rtl/core/crpa_pkg.sv
// ----------------------------------------------------------------------------
// crpa_pkg
// Shared constants and codes for the clip region point/area test block.
// ----------------------------------------------------------------------------
`default_nettype none

package crpa_pkg;

    // default sizing
    localparam int MAX_RECTS_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;

    // port field widths
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int FIELD_W    = 16;
    localparam int VERDICT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int WIN_W      = 15;
    localparam int CNT_W      = 7;

    // item kinds
    localparam logic [KIND_W-1:0] K_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] K_RESET = 2'd1;
    localparam logic [KIND_W-1:0] K_POINT = 2'd2;
    localparam logic [KIND_W-1:0] K_AREA  = 2'd3;

    // verdicts
    localparam logic [VERDICT_W-1:0] V_INVIS   = 2'd0;
    localparam logic [VERDICT_W-1:0] V_VIS     = 2'd1;
    localparam logic [VERDICT_W-1:0] V_PARTIAL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/crpa_ram.sv
// ----------------------------------------------------------------------------
// crpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crpa_ram #(
    parameter int WIDTH = 4 * crpa_pkg::COORD_BITS_DEF,
    parameter int DEPTH = crpa_pkg::MAX_RECTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/crpa_box_unit.sv
// ----------------------------------------------------------------------------
// crpa_box_unit
// Shared compare unit: point-in-box test and empty-box shrink step.
// ----------------------------------------------------------------------------
`default_nettype none

module crpa_box_unit #(
    parameter int CB = crpa_pkg::COORD_BITS_DEF
) (
    input  logic signed [CB-1:0] i_px,
    input  logic signed [CB-1:0] i_py,
    input  logic [4*CB-1:0]      i_box,  // left, top, right, bottom
    input  logic [4*CB-1:0]      i_bnd,  // min_x, min_y, max_x, max_y
    output logic                 o_inside,
    output logic [4*CB-1:0]      o_bnd
);

    localparam logic signed [CB-1:0] ONE = CB'(1);

    logic signed [CB-1:0] w_l, w_t, w_r, w_b;
    logic signed [CB-1:0] w_mnx, w_mny, w_mxx, w_mxy;
    logic signed [CB-1:0] n_mnx, n_mny, n_mxx, n_mxy;

    assign {w_l, w_t, w_r, w_b}         = i_box;
    assign {w_mnx, w_mny, w_mxx, w_mxy} = i_bnd;

    assign o_inside = (i_px >= w_l) && (i_py >= w_t) && (i_px <= w_r) && (i_py <= w_b);

    assign n_mnx = ((i_px > w_r) && (w_r >= w_mnx)) ? w_r + ONE : w_mnx;
    assign n_mny = ((i_py > w_b) && (w_b >= w_mny)) ? w_b + ONE : w_mny;
    assign n_mxx = ((i_px < w_l) && (w_l <= w_mxx)) ? w_l - ONE : w_mxx;
    assign n_mxy = ((i_py < w_t) && (w_t <= w_mxy)) ? w_t - ONE : w_mxy;

    assign o_bnd = {n_mnx, n_mny, n_mxx, n_mxy};

endmodule

`default_nettype wire

FILE: rtl/core/clip_region_point_area_test.sv
// ----------------------------------------------------------------------------
// clip_region_point_area_test
// Clip rectangle table with a one-box cache; point and area visibility test.
// ----------------------------------------------------------------------------
// One word in, one verdict word out. Loads and cache resets need no scan of
// the table, nor does a point or area corner that hits the cached box, or a
// miss decided by the window bounds or a zero count. Otherwise the table is
// scanned through its single read port, one entry per cycle; a full miss
// scans the active rectangles twice. The input is not ready while a word is
// in progress; a finished verdict sits in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clip_region_point_area_test #(
    parameter int MAX_RECTS  = crpa_pkg::MAX_RECTS_DEF,
    parameter int COORD_BITS = crpa_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [crpa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [crpa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [crpa_pkg::KIND_W-1:0]          i_kind,
    input  logic [crpa_pkg::SLOT_W-1:0]          i_slot,
    input  logic signed [crpa_pkg::FIELD_W-1:0]  i_x_a,
    input  logic signed [crpa_pkg::FIELD_W-1:0]  i_y_a,
    input  logic signed [crpa_pkg::FIELD_W-1:0]  i_x_b,
    input  logic signed [crpa_pkg::FIELD_W-1:0]  i_y_b,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [crpa_pkg::VERDICT_W-1:0]       o_verdict
);

    import crpa_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int BW = 4 * CB;

    localparam logic signed [32:0]   CMAX_W = (33'sd1 <<< (CB - 1)) - 33'sd1;
    localparam logic signed [32:0]   CMIN_W = -CMAX_W - 33'sd1;
    localparam logic signed [CB-1:0] CMAX   = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN   = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] CNEG1  = {CB{1'b1}};
    localparam logic signed [CB-1:0] CZERO  = '0;
    localparam logic signed [CB-1:0] CONE   = CB'(1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RST_RD = 4'd1;
    localparam logic [3:0] ST_RST_LD = 4'd2;
    localparam logic [3:0] ST_CHK_A  = 4'd3;
    localparam logic [3:0] ST_MISS   = 4'd4;
    localparam logic [3:0] ST_SCAN1  = 4'd5;
    localparam logic [3:0] ST_SCAN2  = 4'd6;
    localparam logic [3:0] ST_CHK_B  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    function automatic logic signed [CB-1:0] to_coord(input logic signed [FIELD_W-1:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        if (w > CMAX_W) begin
            w = CMAX_W;
        end else if (w < CMIN_W) begin
            w = CMIN_W;
        end
        return w[CB-1:0];
    endfunction

    // control and cache state
    logic [3:0]           r_state, n_state;
    logic [WIN_W-1:0]     r_win_w, r_win_h;
    logic [CNT_W-1:0]     r_rect_count;
    logic signed [CB-1:0] r_cmin_x, r_cmin_y, r_cmax_x, r_cmax_y;
    logic signed [CB-1:0] n_cmin_x, n_cmin_y, n_cmax_x, n_cmax_y;
    logic                 r_cvis, n_cvis;
    logic [CW-1:0]        r_issue, n_issue;
    logic                 r_dvalid, n_dvalid;
    logic                 r_out_valid, n_out_valid;

    // payload
    logic [KIND_W-1:0]    r_kind;
    logic signed [CB-1:0] r_xa, r_ya, r_xb, r_yb;
    logic [VERDICT_W-1:0] r_res, n_res;
    logic [VERDICT_W-1:0] r_verdict, n_verdict;

    logic                 w_in_acc;
    logic signed [CB-1:0] w_xa, w_ya, w_xb, w_yb;
    logic signed [32:0]   w_ww, w_hh;
    logic signed [CB-1:0] w_w, w_h;
    logic [31:0]          w_cnt32, w_slot32;
    logic [CW-1:0]        w_n;
    logic                 w_slot_ok, w_we, w_re;
    logic [AW-1:0]        w_raddr;
    logic [BW-1:0]        w_rdata, w_box, w_cache, w_bnd;
    logic signed [CB-1:0] w_px, w_py;
    logic                 w_inside;
    logic                 w_scan, w_more;
    logic [3:0]           w_after;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_xa     = to_coord(i_x_a);
    assign w_ya     = to_coord(i_y_a);
    assign w_xb     = to_coord(i_x_b);
    assign w_yb     = to_coord(i_y_b);

    assign w_ww = ($signed({18'b0, r_win_w}) > CMAX_W) ? CMAX_W : $signed({18'b0, r_win_w});
    assign w_hh = ($signed({18'b0, r_win_h}) > CMAX_W) ? CMAX_W : $signed({18'b0, r_win_h});
    assign w_w  = w_ww[CB-1:0];
    assign w_h  = w_hh[CB-1:0];

    assign w_cnt32 = {25'b0, r_rect_count};
    assign w_n     = (w_cnt32 > 32'(MAX_RECTS)) ? CW'(MAX_RECTS) : w_cnt32[CW-1:0];

    assign w_slot32  = {26'b0, i_slot};
    assign w_slot_ok = w_slot32 < 32'(MAX_RECTS);
    assign w_we      = w_in_acc && (i_kind == K_LOAD) && w_slot_ok;

    assign w_scan  = (r_state == ST_SCAN1) || (r_state == ST_SCAN2);
    assign w_more  = r_issue < w_n;
    assign w_re    = (r_state == ST_RST_RD) || (w_scan && w_more);
    assign w_raddr = (r_state == ST_RST_RD) ? '0 : r_issue[AW-1:0];

    crpa_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_RECTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot32[AW-1:0]),
        .i_wdata ({w_xa, w_ya, w_xb, w_yb}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cache = {r_cmin_x, r_cmin_y, r_cmax_x, r_cmax_y};
    assign w_box   = w_scan ? w_rdata : w_cache;
    assign w_px    = (r_state == ST_CHK_B) ? r_xb : r_xa;
    assign w_py    = (r_state == ST_CHK_B) ? r_yb : r_ya;

    crpa_box_unit #(
        .CB (CB)
    ) u_unit (
        .i_px     (w_px),
        .i_py     (w_py),
        .i_box    (w_box),
        .i_bnd    (w_cache),
        .o_inside (w_inside),
        .o_bnd    (w_bnd)
    );

    assign w_after = (r_kind == K_AREA) ? ST_CHK_B : ST_DONE;

    always_comb begin
        n_state     = r_state;
        n_cmin_x    = r_cmin_x;
        n_cmin_y    = r_cmin_y;
        n_cmax_x    = r_cmax_x;
        n_cmax_y    = r_cmax_y;
        n_cvis      = r_cvis;
        n_issue     = r_issue;
        n_dvalid    = 1'b0;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_verdict   = r_verdict;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_res = V_INVIS;
                    unique case (i_kind)
                        K_LOAD: begin
                            n_state = ST_DONE;
                        end
                        K_RESET: begin
                            if (w_n == '0) begin
                                {n_cmin_x, n_cmin_y} = {CMIN, CMIN};
                                {n_cmax_x, n_cmax_y} = {CMAX, CMAX};
                                n_cvis  = 1'b0;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_RST_RD;
                            end
                        end
                        K_POINT, K_AREA: begin
                            n_state = ST_CHK_A;
                        end
                    endcase
                end
            end
            ST_RST_RD: begin
                n_state = ST_RST_LD;
            end
            ST_RST_LD: begin
                {n_cmin_x, n_cmin_y, n_cmax_x, n_cmax_y} = w_rdata;
                n_cvis  = 1'b1;
                n_state = ST_DONE;
            end
            ST_CHK_A: begin
                if (w_inside) begin
                    n_res   = r_cvis ? V_VIS : V_INVIS;
                    n_state = w_after;
                end else begin
                    n_state = ST_MISS;
                end
            end
            ST_MISS: begin
                n_issue = '0;
                n_res   = V_INVIS;
                n_state = w_after;
                priority if (r_xa < CZERO) begin
                    {n_cmin_x, n_cmin_y, n_cmax_x, n_cmax_y} = {CMIN, CMIN, CNEG1, CMAX};
                    n_cvis = 1'b0;
                end else if (r_ya < CZERO) begin
                    {n_cmin_x, n_cmin_y, n_cmax_x, n_cmax_y} = {CMIN, CMIN, CMAX, CNEG1};
                    n_cvis = 1'b0;
                end else if (r_xa >= w_w) begin
                    {n_cmin_x, n_cmin_y, n_cmax_x, n_cmax_y} = {w_w, CMIN, CMAX, CMAX};
                    n_cvis = 1'b0;
                end else if (r_ya >= w_h) begin
                    {n_cmin_x, n_cmin_y, n_cmax_x, n_cmax_y} = {CMIN, w_h, CMAX, CMAX};
                    n_cvis = 1'b0;
                end else if (w_n == '0) begin
                    {n_cmin_x, n_cmin_y} = {CZERO, CZERO};
                    n_cmax_x = w_w - CONE;
                    n_cmax_y = w_h - CONE;
                    n_cvis   = 1'b1;
                    n_res    = V_VIS;
                end else begin
                    n_state = ST_SCAN1;
                end
            end
            ST_SCAN1: begin
                if (w_more) begin
                    n_issue  = r_issue + CW'(1);
                    n_dvalid = 1'b1;
                end
                if (r_dvalid && w_inside) begin
                    {n_cmin_x, n_cmin_y, n_cmax_x, n_cmax_y} = w_rdata;
                    n_cvis   = 1'b1;
                    n_res    = V_VIS;
                    n_dvalid = 1'b0;
                    n_state  = w_after;
                end else if (!r_dvalid && !w_more) begin
                    // no hit: restart from the whole plane and shrink
                    {n_cmin_x, n_cmin_y} = {CMIN, CMIN};
                    {n_cmax_x, n_cmax_y} = {CMAX, CMAX};
                    n_cvis  = 1'b0;
                    n_issue = '0;
                    n_state = ST_SCAN2;
                end
            end
            ST_SCAN2: begin
                if (w_more) begin
                    n_issue  = r_issue + CW'(1);
                    n_dvalid = 1'b1;
                end
                if (r_dvalid) begin
                    {n_cmin_x, n_cmin_y, n_cmax_x, n_cmax_y} = w_bnd;
                end else if (!w_more) begin
                    n_res   = V_INVIS;
                    n_state = w_after;
                end
            end
            ST_CHK_B: begin
                n_res   = w_inside ? (r_cvis ? V_VIS : V_INVIS) : V_PARTIAL;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_verdict   = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_win_w      <= '0;
            r_win_h      <= '0;
            r_rect_count <= '0;
            r_cmin_x     <= CMIN;
            r_cmin_y     <= CMIN;
            r_cmax_x     <= CMAX;
            r_cmax_y     <= CMAX;
            r_cvis       <= 1'b0;
            r_issue      <= '0;
            r_dvalid     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmin_x    <= n_cmin_x;
            r_cmin_y    <= n_cmin_y;
            r_cmax_x    <= n_cmax_x;
            r_cmax_y    <= n_cmax_y;
            r_cvis      <= n_cvis;
            r_issue     <= n_issue;
            r_dvalid    <= n_dvalid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WIN_W: r_win_w      <= i_cfg_data[WIN_W-1:0];
                    CFG_WIN_H: r_win_h      <= i_cfg_data[WIN_W-1:0];
                    CFG_COUNT: r_rect_count <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_kind;
            r_xa   <= w_xa;
            r_ya   <= w_ya;
            r_xb   <= w_xb;
            r_yb   <= w_yb;
        end
        r_res     <= n_res;
        r_verdict <= n_verdict;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // a word in progress blocks the input until its verdict is registered
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input ready right after accepting a word");

    // scan index never runs past the active count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan |-> (r_issue <= w_n))
        else $error("table scan index beyond active count");

    // point tests never report partial
    a_point_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && (r_kind == K_POINT) |-> (r_res != V_PARTIAL))
        else $error("point test produced a partial verdict");

    // a verdict goes out only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("output word raised outside the done state");

endmodule

`default_nettype wire
